FILE: hw/rtl/hrc_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// Used by the arithmetic pipeline, the top level and the port checker.
`timescale 1ns / 1ps

package hrc_pkg;

  // Hue geometry and level scale
  localparam int unsigned HUE_W        = 9;
  localparam int unsigned LVL_W        = 8;
  localparam int unsigned REM_W        = 6;
  localparam int unsigned HUE_SECTOR   = 60;
  localparam int unsigned HUE_FULL     = 360;
  localparam int unsigned LEVEL_MAX    = 255;
  localparam int unsigned SECTOR_SCALE = HUE_SECTOR * LEVEL_MAX;  // 15300

  // Product widths
  localparam int unsigned PROD_W = 14;  // s * rem, s * (60 - rem): up to 15300
  localparam int unsigned PNUM_W = 16;  // v * (255 - s)
  localparam int unsigned QNUM_W = 22;  // v * (15300 - prod)

  // Reciprocal multipliers for the constant divides (estimate low by at most one)
  localparam int unsigned Q_RECIP = (1 << QNUM_W) / SECTOR_SCALE;  // 274
  localparam int unsigned P_RECIP = 257;
  localparam int unsigned Q_EST_W = QNUM_W + 9;
  localparam int unsigned P_EST_W = PNUM_W + 9;

  // Stream widths
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 24;

  // Hue sector, sixty degrees each
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  // Channel candidates handed from the pipeline to the output stage
  typedef struct packed {
    sector_e           sec;
    logic [LVL_W-1:0]  v;
    logic [LVL_W-1:0]  p;
    logic [LVL_W-1:0]  q;
    logic [LVL_W-1:0]  t;
  } hrc_chan_t;

endpackage

FILE: hw/rtl/hrc_pipe.sv
// Five-stage arithmetic pipeline of the HSV to RGB converter: sector split,
// products, scaled numerators, reciprocal estimates and remainder correction.
// Depends on hrc_pkg.
`timescale 1ns / 1ps

module hrc_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  input  logic [hrc_pkg::HUE_W-1:0] in_hue_i,
  input  logic [hrc_pkg::LVL_W-1:0] in_sat_i,
  input  logic [hrc_pkg::LVL_W-1:0] in_val_i,
  output logic                      out_valid_o,
  output hrc_pkg::hrc_chan_t        out_chan_o
);
  import hrc_pkg::*;

  // Stage registers
  logic                   vld1_q, vld2_q, vld3_q, vld4_q, vld5_q;
  sector_e                sec1_q, sec2_q, sec3_q, sec4_q;
  logic [REM_W-1:0]       rem1_q;
  logic [LVL_W-1:0]       s1_q;
  logic [LVL_W-1:0]       v1_q, v2_q, v3_q, v4_q;
  logic [PROD_W-1:0]      prq2_q, prt2_q;
  logic [PNUM_W-1:0]      pn2_q, pn3_q, pn4_q;
  logic [QNUM_W-1:0]      qn3_q, tn3_q, qn4_q, tn4_q;
  logic [LVL_W-1:0]       pe4_q, qe4_q, te4_q;
  hrc_chan_t              chan5_q;

  // Stage 1 combinational: wrap hue and split into sector and remainder
  logic [HUE_W-1:0] hue_w;
  logic [HUE_W-1:0] rem_full;
  sector_e          sec_d;

  always_comb begin
    hue_w = (in_hue_i >= HUE_W'(HUE_FULL)) ? in_hue_i - HUE_W'(HUE_FULL) : in_hue_i;
    if (hue_w < HUE_W'(HUE_SECTOR)) begin
      sec_d    = SEC_RY;
      rem_full = hue_w;
    end else if (hue_w < HUE_W'(2 * HUE_SECTOR)) begin
      sec_d    = SEC_YG;
      rem_full = hue_w - HUE_W'(HUE_SECTOR);
    end else if (hue_w < HUE_W'(3 * HUE_SECTOR)) begin
      sec_d    = SEC_GC;
      rem_full = hue_w - HUE_W'(2 * HUE_SECTOR);
    end else if (hue_w < HUE_W'(4 * HUE_SECTOR)) begin
      sec_d    = SEC_CB;
      rem_full = hue_w - HUE_W'(3 * HUE_SECTOR);
    end else if (hue_w < HUE_W'(5 * HUE_SECTOR)) begin
      sec_d    = SEC_BM;
      rem_full = hue_w - HUE_W'(4 * HUE_SECTOR);
    end else begin
      sec_d    = SEC_MR;
      rem_full = hue_w - HUE_W'(5 * HUE_SECTOR);
    end
  end

  // Stage 4 combinational: reciprocal estimates of the constant divides
  logic [Q_EST_W-1:0] qe_full, te_full;
  logic [P_EST_W-1:0] pe_full;

  always_comb begin
    qe_full = Q_EST_W'(qn3_q) * Q_EST_W'(Q_RECIP);
    te_full = Q_EST_W'(tn3_q) * Q_EST_W'(Q_RECIP);
    pe_full = P_EST_W'(pn3_q) * P_EST_W'(P_RECIP);
  end

  // Stage 5 combinational: correct each estimate by one remainder compare
  logic [QNUM_W-1:0] qr, tr;
  logic [PNUM_W-1:0] pr;
  logic [LVL_W:0]    qc, tc, pc;
  hrc_chan_t         chan5_d;

  always_comb begin
    qr = qn4_q - QNUM_W'(qe4_q) * QNUM_W'(SECTOR_SCALE);
    tr = tn4_q - QNUM_W'(te4_q) * QNUM_W'(SECTOR_SCALE);
    pr = pn4_q - PNUM_W'(pe4_q) * PNUM_W'(LEVEL_MAX);
    qc = {1'b0, qe4_q} + ((qr >= QNUM_W'(SECTOR_SCALE)) ? 9'd1 : 9'd0);
    tc = {1'b0, te4_q} + ((tr >= QNUM_W'(SECTOR_SCALE)) ? 9'd1 : 9'd0);
    pc = {1'b0, pe4_q} + ((pr >= PNUM_W'(LEVEL_MAX)) ? 9'd1 : 9'd0);
    chan5_d.sec = sec4_q;
    chan5_d.v   = v4_q;
    // Saturate to the level range
    chan5_d.q   = qc[LVL_W] ? LVL_W'(LEVEL_MAX) : qc[LVL_W-1:0];
    chan5_d.t   = tc[LVL_W] ? LVL_W'(LEVEL_MAX) : tc[LVL_W-1:0];
    chan5_d.p   = pc[LVL_W] ? LVL_W'(LEVEL_MAX) : pc[LVL_W-1:0];
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  // Advance the payload; hold everything while the output is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1
      sec1_q <= sec_d;
      rem1_q <= rem_full[REM_W-1:0];
      s1_q   <= in_sat_i;
      v1_q   <= in_val_i;
      // stage 2: products of saturation
      sec2_q <= sec1_q;
      v2_q   <= v1_q;
      prq2_q <= PROD_W'(s1_q) * PROD_W'(rem1_q);
      prt2_q <= PROD_W'(s1_q) * (PROD_W'(HUE_SECTOR) - PROD_W'(rem1_q));
      pn2_q  <= PNUM_W'(v1_q) * (PNUM_W'(LEVEL_MAX) - PNUM_W'(s1_q));
      // stage 3: scaled numerators
      sec3_q <= sec2_q;
      v3_q   <= v2_q;
      pn3_q  <= pn2_q;
      qn3_q  <= QNUM_W'(v2_q) * (QNUM_W'(SECTOR_SCALE) - QNUM_W'(prq2_q));
      tn3_q  <= QNUM_W'(v2_q) * (QNUM_W'(SECTOR_SCALE) - QNUM_W'(prt2_q));
      // stage 4: quotient estimates
      sec4_q <= sec3_q;
      v4_q   <= v3_q;
      pn4_q  <= pn3_q;
      qn4_q  <= qn3_q;
      tn4_q  <= tn3_q;
      qe4_q  <= qe_full[QNUM_W +: LVL_W];
      te4_q  <= te_full[QNUM_W +: LVL_W];
      pe4_q  <= pe_full[PNUM_W +: LVL_W];
      // stage 5: corrected quotients
      chan5_q <= chan5_d;
    end
  end

  assign out_valid_o = vld5_q;
  assign out_chan_o  = chan5_q;

endmodule

FILE: hw/rtl/hsv_to_rgb_converter_core.sv
// Top level of the HSV to RGB converter: stream ports, pipeline and output stage.
// Depends on hrc_pkg and hrc_pipe.
`timescale 1ns / 1ps

// Converts one hue/saturation/value request per clock, unless the master side
// stalls, into 8-bit red, green and blue. Throughput is one request per cycle
// while no result waits on the master side. The request passes six register
// stages, the first of which captures it at the accepting edge: the five
// arithmetic stages (sector split, saturation products, scaled numerators,
// reciprocal estimates, remainder correction) and the channel-select output
// register. All stages share one enable, so a stalled master freezes the whole
// pipeline and s_axis_tready follows m_axis_tready whenever the output holds a
// result. Hues of 360 and above wrap by subtracting 360. No reset sweep and no
// configuration: the block is ready as soon as reset is released.
module hsv_to_rgb_converter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [8:0] hue, [16:9] saturation, [24:17] brightness, [31:25] zero
  input  logic [hrc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [hrc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import hrc_pkg::*;

  logic      en;
  logic      pipe_vld;
  hrc_chan_t pipe_chan;
  logic      out_vld_q;
  logic [LVL_W-1:0] red_d, green_d, blue_d;
  logic [LVL_W-1:0] red_q, green_q, blue_q;

  // Advance the whole pipeline unless a result waits on the master side
  assign en            = !(out_vld_q && !m_axis_tready);
  assign s_axis_tready = en;

  hrc_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s_axis_tvalid),
    .in_hue_i    (s_axis_tdata[HUE_W-1:0]),
    .in_sat_i    (s_axis_tdata[HUE_W +: LVL_W]),
    .in_val_i    (s_axis_tdata[HUE_W+LVL_W +: LVL_W]),
    .out_valid_o (pipe_vld),
    .out_chan_o  (pipe_chan)
  );

  // Route v, p, q, t to the channels by sector
  always_comb begin
    case (pipe_chan.sec)
      SEC_RY: begin
        red_d = pipe_chan.v; green_d = pipe_chan.t; blue_d = pipe_chan.p;
      end
      SEC_YG: begin
        red_d = pipe_chan.q; green_d = pipe_chan.v; blue_d = pipe_chan.p;
      end
      SEC_GC: begin
        red_d = pipe_chan.p; green_d = pipe_chan.v; blue_d = pipe_chan.t;
      end
      SEC_CB: begin
        red_d = pipe_chan.p; green_d = pipe_chan.q; blue_d = pipe_chan.v;
      end
      SEC_BM: begin
        red_d = pipe_chan.t; green_d = pipe_chan.p; blue_d = pipe_chan.v;
      end
      default: begin
        red_d = pipe_chan.v; green_d = pipe_chan.p; blue_d = pipe_chan.q;
      end
    endcase
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= pipe_vld;
    end
  end

  // Output payload; hold while stalled
  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {blue_q, green_q, red_q};

endmodule

FILE: hw/rtl/hrc_checker.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
// Depends on hrc_pkg and hsv_to_rgb_converter_core.
`timescale 1ns / 1ps

module hrc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [hrc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [hrc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import hrc_pkg::*;

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // No request is taken while a result waits
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while output stalled");

  // With the output free the input side is always open
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input closed with free output");

  // An accepted request carries known data
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata))
    else $error("request accepted with unknown data");

  // Nothing comes out in the first cycle after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result present right after reset");

endmodule

bind hsv_to_rgb_converter_core hrc_checker u_hrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
